// ===== rtl/core/vpp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package vpp_pkg;

	localparam int CW = 32;             // internal coordinate width, 24..48
	localparam int NUM_REGS = 8;
	localparam int IDX_W = 3;
	localparam int CFG_W = 64;
	localparam int WIDE = 96;
	localparam int LP_W = 48;           // local coord times basis coefficient
	localparam int VP_W = CW + 16;      // view delta times camera coefficient
	localparam int NUM_W = 44;          // focal << 28
	localparam int F_W = 32;            // perspective factor, below 2^32 once visible
	localparam int MX_W = CW + F_W + 1;
	localparam int MD_W = CW + 23;
	localparam logic signed [CW-1:0] DEPTH_MIN = CW'(6554);
	localparam logic signed [22:0] DEPTH_SCALE = 23'sd1052770;

	localparam logic [IDX_W-1:0] REG_ORIGIN_XY = 3'd0;
	localparam logic [IDX_W-1:0] REG_ORIGIN_Z_CAM_X = 3'd1;
	localparam logic [IDX_W-1:0] REG_CAM_YZ = 3'd2;
	localparam logic [IDX_W-1:0] REG_BASIS_A = 3'd3;
	localparam logic [IDX_W-1:0] REG_BASIS_B = 3'd4;
	localparam logic [IDX_W-1:0] REG_BASIS_C = 3'd5;
	localparam logic [IDX_W-1:0] REG_VIEW_A = 3'd6;
	localparam logic [IDX_W-1:0] REG_VIEW_B = 3'd7;

	typedef struct packed {
		logic signed [31:0] local_x;
		logic signed [31:0] local_y;
		logic signed [31:0] local_z;
		logic               last_in;
	} vpp_in_t;

	typedef struct packed {
		logic signed [31:0] screen_x;
		logic signed [31:0] screen_y;
		logic signed [31:0] depth;
		logic               visible;
		logic               last_out;
	} vpp_out_t;

	typedef struct packed {
		logic signed [31:0] ox, oy, oz, cx, cy, cz;
		logic signed [15:0] rx, ry, rz, ux, uy, uz, fx, fy, fz;
		logic signed [15:0] vfx, vfy, vfz, vrx, vrz, vux, vuy, vuz;
		logic [15:0]        focal, hw, hh;
	} vpp_cfg_t;

	typedef struct packed {
		logic signed [CW-1:0] nx;
		logic signed [CW-1:0] ny;
		logic signed [CW-1:0] cz;
		logic                 vis;
		logic                 last;
	} vpp_side_t;

	localparam logic signed [WIDE-1:0] CW_MAX = (WIDE'(1) <<< (CW - 1)) - WIDE'(1);
	localparam logic signed [WIDE-1:0] CW_MIN = -CW_MAX - WIDE'(1);
	localparam logic signed [WIDE-1:0] W32_MAX = (WIDE'(1) <<< 31) - WIDE'(1);
	localparam logic signed [WIDE-1:0] W32_MIN = -W32_MAX - WIDE'(1);

	function automatic logic signed [CW-1:0] sat_cw(input logic signed [WIDE-1:0] v);
		logic signed [WIDE-1:0] r;
		r = v;
		if (v > CW_MAX) r = CW_MAX;
		else if (v < CW_MIN) r = CW_MIN;
		return r[CW-1:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [WIDE-1:0] v);
		logic signed [WIDE-1:0] r;
		r = v;
		if (v > W32_MAX) r = W32_MAX;
		else if (v < W32_MIN) r = W32_MIN;
		return r[31:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/vpp_xform.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vpp_xform
	import vpp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  wire logic      in_vld,
	input  wire vpp_in_t   in_item,
	input  wire vpp_cfg_t  cfg,
	output logic           out_vld,
	output vpp_side_t      out_side
);

	logic signed [LP_W-1:0] p_s1 [9];
	logic                   last_s1, v_s1;
	logic signed [CW-1:0]   w_s2 [3];
	logic                   last_s2, v_s2;
	logic signed [CW-1:0]   d_s3 [3];
	logic                   last_s3, v_s3;
	logic signed [VP_W-1:0] q_s4 [8];
	logic                   last_s4, v_s4;
	vpp_side_t              side_s5;
	logic                   v_s5;

	logic signed [39:0]     wsum [3];
	logic signed [CW+5:0]   czs, nxs, nys;

	always_comb begin
		wsum[0] = 40'(cfg.ox) + 40'(p_s1[0] >>> 12) + 40'(p_s1[1] >>> 12) + 40'(p_s1[2] >>> 12);
		wsum[1] = 40'(cfg.oy) + 40'(p_s1[3] >>> 12) + 40'(p_s1[4] >>> 12) + 40'(p_s1[5] >>> 12);
		wsum[2] = 40'(cfg.oz) + 40'(p_s1[6] >>> 12) + 40'(p_s1[7] >>> 12) + 40'(p_s1[8] >>> 12);
		czs = (CW+6)'(q_s4[0] >>> 12) + (CW+6)'(q_s4[1] >>> 12) + (CW+6)'(q_s4[2] >>> 12);
		nxs = (CW+6)'(q_s4[3] >>> 12) + (CW+6)'(q_s4[4] >>> 12);
		nys = (CW+6)'(q_s4[5] >>> 12) + (CW+6)'(q_s4[6] >>> 12) + (CW+6)'(q_s4[7] >>> 12);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// object basis: right, up, forward columns
			p_s1[0] <= LP_W'(in_item.local_x) * LP_W'(cfg.rx);
			p_s1[1] <= LP_W'(in_item.local_y) * LP_W'(cfg.ux);
			p_s1[2] <= LP_W'(in_item.local_z) * LP_W'(cfg.fx);
			p_s1[3] <= LP_W'(in_item.local_x) * LP_W'(cfg.ry);
			p_s1[4] <= LP_W'(in_item.local_y) * LP_W'(cfg.uy);
			p_s1[5] <= LP_W'(in_item.local_z) * LP_W'(cfg.fy);
			p_s1[6] <= LP_W'(in_item.local_x) * LP_W'(cfg.rz);
			p_s1[7] <= LP_W'(in_item.local_y) * LP_W'(cfg.uz);
			p_s1[8] <= LP_W'(in_item.local_z) * LP_W'(cfg.fz);
			last_s1 <= in_item.last_in;

			for (int i = 0; i < 3; i++) w_s2[i] <= sat_cw(WIDE'(wsum[i]));
			last_s2 <= last_s1;

			d_s3[0] <= sat_cw(WIDE'(w_s2[0]) - WIDE'(cfg.cx));
			d_s3[1] <= sat_cw(WIDE'(w_s2[1]) - WIDE'(cfg.cy));
			d_s3[2] <= sat_cw(WIDE'(w_s2[2]) - WIDE'(cfg.cz));
			last_s3 <= last_s2;

			q_s4[0] <= VP_W'(d_s3[0]) * VP_W'(cfg.vfx);
			q_s4[1] <= VP_W'(d_s3[1]) * VP_W'(cfg.vfy);
			q_s4[2] <= VP_W'(d_s3[2]) * VP_W'(cfg.vfz);
			// screen x uses only the right x and z terms
			q_s4[3] <= VP_W'(d_s3[0]) * VP_W'(cfg.vrx);
			q_s4[4] <= VP_W'(d_s3[2]) * VP_W'(cfg.vrz);
			q_s4[5] <= VP_W'(d_s3[0]) * VP_W'(cfg.vux);
			q_s4[6] <= VP_W'(d_s3[1]) * VP_W'(cfg.vuy);
			q_s4[7] <= VP_W'(d_s3[2]) * VP_W'(cfg.vuz);
			last_s4 <= last_s3;

			side_s5.cz <= sat_cw(WIDE'(czs));
			side_s5.vis <= sat_cw(WIDE'(czs)) >= DEPTH_MIN;
			side_s5.nx <= sat_cw(WIDE'(nxs));
			side_s5.ny <= sat_cw(WIDE'(nys));
			side_s5.last <= last_s4;
		end
	end

	assign out_vld = v_s5;
	assign out_side = side_s5;

endmodule
`default_nettype wire

// ===== rtl/core/vpp_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vpp_div
	import vpp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  wire logic      in_vld,
	input  wire vpp_side_t in_side,
	input  wire logic [15:0] focal,
	output logic           out_vld,
	output vpp_side_t      out_side,
	output logic [F_W-1:0] f
);

	// restoring divider, one quotient bit per stage
	logic [CW-2:0]    rem_s [NUM_W+1];
	logic [CW-2:0]    den_s [NUM_W+1];
	logic [NUM_W-1:0] num_s [NUM_W+1];
	logic [NUM_W-1:0] quo_s [NUM_W+1];
	vpp_side_t        side_s [NUM_W+1];
	logic             v_s [NUM_W+1];

	assign rem_s[0] = '0;
	assign den_s[0] = in_side.vis ? in_side.cz[CW-2:0] : (CW-1)'(1);
	assign num_s[0] = {focal, 28'b0};
	assign quo_s[0] = '0;
	assign side_s[0] = in_side;
	assign v_s[0] = in_vld;

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic [CW-1:0] shifted;
		logic          ge;

		always_comb begin
			shifted = {rem_s[k], num_s[k][NUM_W-1]};
			ge = shifted >= {1'b0, den_s[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k+1] <= 1'b0;
			else if (en) v_s[k+1] <= v_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? (CW-1)'(shifted - {1'b0, den_s[k]}) : shifted[CW-2:0];
				den_s[k+1] <= den_s[k];
				num_s[k+1] <= {num_s[k][NUM_W-2:0], 1'b0};
				quo_s[k+1] <= {quo_s[k][NUM_W-2:0], ge};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_vld = v_s[NUM_W];
	assign out_side = side_s[NUM_W];
	assign f = quo_s[NUM_W][F_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/core/vpp_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vpp_scale
	import vpp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  wire logic      in_vld,
	input  wire vpp_side_t in_side,
	input  wire logic [F_W-1:0] f,
	input  wire vpp_cfg_t  cfg,
	output logic           out_vld,
	output vpp_out_t       out_item
);

	logic signed [MX_W-1:0] mx_s1, my_s1;
	logic signed [MD_W-1:0] md_s1;
	logic                   vis_s1, last_s1, v_s1;
	logic signed [31:0]     tx_s2, ty_s2, td_s2;
	logic                   vis_s2, last_s2, v_s2;
	vpp_out_t               out_s3;
	logic                   v_s3;

	logic signed [33:0]     hwx, hhx;

	assign hwx = $signed({6'b0, cfg.hw, 12'b0});
	assign hhx = $signed({6'b0, cfg.hh, 12'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1 <= MX_W'(in_side.nx) * MX_W'($signed({1'b0, f}));
			my_s1 <= MX_W'(in_side.ny) * MX_W'($signed({1'b0, f}));
			md_s1 <= MD_W'(in_side.cz) * MD_W'(DEPTH_SCALE);
			vis_s1 <= in_side.vis;
			last_s1 <= in_side.last;

			tx_s2 <= sat32(WIDE'(mx_s1 >>> 16));
			ty_s2 <= sat32(WIDE'(my_s1 >>> 16));
			td_s2 <= sat32(WIDE'(md_s1 >>> 20));
			vis_s2 <= vis_s1;
			last_s2 <= last_s1;

			// zero everything but last for a vertex behind the near limit
			out_s3.screen_x <= vis_s2 ? sat32(WIDE'(hwx) + WIDE'(tx_s2)) : '0;
			out_s3.screen_y <= vis_s2 ? sat32(WIDE'(hhx) + WIDE'(ty_s2)) : '0;
			out_s3.depth <= vis_s2 ? td_s2 : '0;
			out_s3.visible <= vis_s2;
			out_s3.last_out <= last_s2;
		end
	end

	assign out_vld = v_s3;
	assign out_item = out_s3;

endmodule
`default_nettype wire

// ===== rtl/core/vertex_perspective_projection_core.sv =====
// Throughput: one vertex per cycle while the output is not stalled;
// 5 transform stages, a 44-stage restoring divider for the perspective
// factor and 3 scaling stages run from an accepted vertex to its result.
// A stall at a valid output freezes the whole pipeline and raises in_stall.
// Reset (arst_n low, asynchronous) clears all valid bits and all
// configuration registers to zero.
`timescale 1ns / 1ps
`default_nettype none
module vertex_perspective_projection_core
	import vpp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire vpp_in_t          in_item,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output vpp_out_t              out_item,
	input  wire logic             cfg_we,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	logic [CFG_W-1:0] regs_q [NUM_REGS];
	vpp_cfg_t         cfg;
	logic             en;
	logic             xf_vld, dv_vld;
	vpp_side_t        xf_side, dv_side;
	logic [F_W-1:0]   f;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) regs_q[i] <= '0;
		end else if (cfg_we) begin
			regs_q[cfg_index] <= cfg_data;
		end
	end

	always_comb begin
		cfg.ox = regs_q[REG_ORIGIN_XY][31:0];
		cfg.oy = regs_q[REG_ORIGIN_XY][63:32];
		cfg.oz = regs_q[REG_ORIGIN_Z_CAM_X][31:0];
		cfg.cx = regs_q[REG_ORIGIN_Z_CAM_X][63:32];
		cfg.cy = regs_q[REG_CAM_YZ][31:0];
		cfg.cz = regs_q[REG_CAM_YZ][63:32];
		cfg.rx = regs_q[REG_BASIS_A][15:0];
		cfg.ry = regs_q[REG_BASIS_A][31:16];
		cfg.rz = regs_q[REG_BASIS_A][47:32];
		cfg.ux = regs_q[REG_BASIS_A][63:48];
		cfg.uy = regs_q[REG_BASIS_B][15:0];
		cfg.uz = regs_q[REG_BASIS_B][31:16];
		cfg.fx = regs_q[REG_BASIS_B][47:32];
		cfg.fy = regs_q[REG_BASIS_B][63:48];
		cfg.fz = regs_q[REG_BASIS_C][15:0];
		cfg.vfx = regs_q[REG_BASIS_C][31:16];
		cfg.vfy = regs_q[REG_BASIS_C][47:32];
		cfg.vfz = regs_q[REG_BASIS_C][63:48];
		cfg.vrx = regs_q[REG_VIEW_A][15:0];
		cfg.vrz = regs_q[REG_VIEW_A][31:16];
		cfg.vux = regs_q[REG_VIEW_A][47:32];
		cfg.vuy = regs_q[REG_VIEW_A][63:48];
		cfg.vuz = regs_q[REG_VIEW_B][15:0];
		cfg.focal = regs_q[REG_VIEW_B][31:16];
		cfg.hw = regs_q[REG_VIEW_B][47:32];
		cfg.hh = regs_q[REG_VIEW_B][63:48];
	end

	// hold every stage while the output transaction waits
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	vpp_xform u_xform (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (in_valid),
		.in_item  (in_item),
		.cfg      (cfg),
		.out_vld  (xf_vld),
		.out_side (xf_side)
	);

	vpp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (xf_vld),
		.in_side  (xf_side),
		.focal    (cfg.focal),
		.out_vld  (dv_vld),
		.out_side (dv_side),
		.f        (f)
	);

	vpp_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (dv_vld),
		.in_side  (dv_side),
		.f        (f),
		.cfg      (cfg),
		.out_vld  (out_valid),
		.out_item (out_item)
	);

endmodule
`default_nettype wire

// ===== rtl/core/vpp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vpp_checker
	import vpp_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_stall,
	input  wire logic     out_valid,
	input  wire logic     out_stall,
	input  wire vpp_out_t out_item
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("output transaction changed while stalled");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without an output stall");

	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.visible |->
			out_item.screen_x == 0 && out_item.screen_y == 0 && out_item.depth == 0)
		else $error("hidden vertex has nonzero coordinates");

	a_depth_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.visible |-> !out_item.depth[31] && out_item.depth != 0)
		else $error("visible vertex has non-positive depth");

endmodule

bind vertex_perspective_projection_core vpp_checker u_vpp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);
`default_nettype wire
